// ===== hdl/ssp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the servo slew PWM controller.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int PWM_BITS   = 16;
	localparam int MAX_DUTY   = (2 ** PWM_BITS) - 1;

	localparam int ACTION_W   = 2;
	localparam int TIME_W     = 32;
	localparam int ANGLE_W    = 8;
	localparam int INTERVAL_W = 10;
	localparam int DUTY_W     = 13;
	localparam int INDEX_W    = 2;
	localparam int WDATA_W    = 10;

	localparam int ANGLE_MAX  = 180;
	localparam int PULSE_BASE = 500;
	localparam int PULSE_SPAN = 2000;
	localparam int PULSE_TOP  = 2500;
	localparam int FRAME_US   = 20000;

	localparam int PULSE_W    = $clog2(PULSE_TOP + 1);
	localparam int PULSE_Q_W  = $clog2(PULSE_SPAN + 1);
	localparam int DUTY_Q_W   = $clog2((PULSE_TOP * MAX_DUTY) / FRAME_US + 1);
	localparam int QUO_W      = (DUTY_Q_W > PULSE_Q_W) ? DUTY_Q_W : PULSE_Q_W;

	// reciprocals rounded up; exact floor for angle <= 180 and pulse <= 2500
	localparam int     PULSE_SH      = 16;
	localparam int     DUTY_SH       = 26;
	localparam longint PULSE_RECIP_V =
		((longint'(PULSE_SPAN) << PULSE_SH) + ANGLE_MAX - 1) / ANGLE_MAX;
	localparam longint DUTY_RECIP_V  =
		((longint'(MAX_DUTY) << DUTY_SH) + FRAME_US - 1) / FRAME_US;
	localparam int     OPA_W         = PULSE_W;
	localparam int     RECIP_W       = $clog2(DUTY_RECIP_V + 1);
	localparam int     PROD_W        = OPA_W + RECIP_W;

	localparam logic [RECIP_W-1:0] PULSE_RECIP = RECIP_W'(PULSE_RECIP_V);
	localparam logic [RECIP_W-1:0] DUTY_RECIP  = RECIP_W'(DUTY_RECIP_V);

	localparam logic [DUTY_W-1:0] DUTY_AT_MIN = DUTY_W'((PULSE_BASE * MAX_DUTY) / FRAME_US);
	localparam logic [DUTY_W-1:0] DUTY_AT_MAX = DUTY_W'((PULSE_TOP * MAX_DUTY) / FRAME_US);

	localparam logic                  ENABLE_RST   = 1'b1;
	localparam logic [ANGLE_W-1:0]    LOCK_RST     = 8'd90;
	localparam logic [ANGLE_W-1:0]    UNLOCK_RST   = 8'd0;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd15;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK   = 2'd0,
		ACT_LOCK   = 2'd1,
		ACT_UNLOCK = 2'd2
	} action_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_ENABLE   = 2'd0,
		REG_LOCK     = 2'd1,
		REG_UNLOCK   = 2'd2,
		REG_INTERVAL = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PULSE,
		ST_DUTY,
		ST_EMIT
	} state_t;

	typedef enum logic {
		SEL_PULSE,
		SEL_DUTY
	} div_sel_t;

	typedef struct packed {
		logic     load;
		div_sel_t sel;
	} div_cmd_t;

	typedef struct packed {
		logic     idle;
		div_cmd_t div;
		logic     emit;
	} ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ssp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_div
// Shared divider by a selected constant: reciprocal multiply, one per cycle.
// ----------------------------------------------------------------------------
module ssp_div (
	input  wire logic                        clk,
	input  wire ssp_pkg::div_cmd_t           cmd,
	input  wire logic [ssp_pkg::OPA_W-1:0]   num,
	output logic      [ssp_pkg::QUO_W-1:0]   quo
);

	logic [ssp_pkg::RECIP_W-1:0] recip;
	logic [ssp_pkg::PROD_W-1:0]  prod;
	logic [ssp_pkg::QUO_W-1:0]   quo_q;

	assign recip = (cmd.sel == ssp_pkg::SEL_DUTY) ? ssp_pkg::DUTY_RECIP : ssp_pkg::PULSE_RECIP;
	assign prod  = ssp_pkg::PROD_W'(num) * ssp_pkg::PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= (cmd.sel == ssp_pkg::SEL_DUTY) ? ssp_pkg::QUO_W'(prod >> ssp_pkg::DUTY_SH)
			                                        : ssp_pkg::QUO_W'(prod >> ssp_pkg::PULSE_SH);
		end
	end

	assign quo = quo_q;

endmodule
`default_nettype wire

// ===== hdl/ssp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer: pulse quotient, duty quotient, then hand-off to the output reg.
// ----------------------------------------------------------------------------
module ssp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          out_busy,
	output ssp_pkg::ctl_t      ctl
);

	ssp_pkg::state_t state_q;
	ssp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssp_pkg::ST_IDLE: begin
				if (req_valid) state_d = ssp_pkg::ST_PULSE;
			end
			ssp_pkg::ST_PULSE: state_d = ssp_pkg::ST_DUTY;
			ssp_pkg::ST_DUTY:  state_d = ssp_pkg::ST_EMIT;
			ssp_pkg::ST_EMIT: begin
				if (!out_busy) state_d = ssp_pkg::ST_IDLE;
			end
			default: state_d = ssp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.idle     = (state_q == ssp_pkg::ST_IDLE);
		ctl.div.load = (state_q == ssp_pkg::ST_PULSE) || (state_q == ssp_pkg::ST_DUTY);
		ctl.div.sel  = (state_q == ssp_pkg::ST_DUTY) ? ssp_pkg::SEL_DUTY
		                                             : ssp_pkg::SEL_PULSE;
		ctl.emit     = (state_q == ssp_pkg::ST_EMIT) && !out_busy;
	end

endmodule
`default_nettype wire

// ===== hdl/servo_slew_pwm_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_slew_pwm_controller
// Slew-limited servo position with PWM duty, one result per request.
// ----------------------------------------------------------------------------
// Request channel: req_valid/req_stall with action and now_ms. A tick may
// step the position one degree toward the target; lock and unlock set the
// target and arm an immediate step on the next tick.
// Response channel: rsp_valid/rsp_stall with duty, position, is_locked and
// moved, held in an output register until taken.
// The state update happens at the accepting edge; rsp_valid rises after the
// states PULSE, DUTY and EMIT, where EMIT waits while the output register is
// stalled. The duty comes from two divisions by constants, done as reciprocal
// multiplies on one shared multiplier, one per cycle. req_stall is high from
// the accepting edge until the result has moved into the output register. A
// stalled response holds its register; the next request can be worked on
// meanwhile and waits at the end for the register to free up.
// Reset: registers return to their defaults, position and target to 0,
// an immediate step is armed, and the response register is empty.
// Configuration writes go through write_enable/write_index/write_data.
// ----------------------------------------------------------------------------
module servo_slew_pwm_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            write_enable,
	input  wire logic [ssp_pkg::INDEX_W-1:0]     write_index,
	input  wire logic [ssp_pkg::WDATA_W-1:0]     write_data,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic [ssp_pkg::ACTION_W-1:0]    action,
	input  wire logic [ssp_pkg::TIME_W-1:0]      now_ms,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic      [ssp_pkg::DUTY_W-1:0]      duty,
	output logic      [ssp_pkg::ANGLE_W-1:0]     position,
	output logic                                 is_locked,
	output logic                                 moved
);

	logic                               enable_q;
	logic [ssp_pkg::ANGLE_W-1:0]        lock_q;
	logic [ssp_pkg::ANGLE_W-1:0]        unlock_q;
	logic [ssp_pkg::INTERVAL_W-1:0]     interval_q;

	logic [ssp_pkg::ANGLE_W-1:0]        cur_q;
	logic [ssp_pkg::ANGLE_W-1:0]        tgt_q;
	logic [ssp_pkg::TIME_W-1:0]         next_q;
	logic                               move_now_q;
	logic                               moved_q;

	logic                               rsp_valid_q;
	logic [ssp_pkg::DUTY_W-1:0]         duty_q;
	logic [ssp_pkg::ANGLE_W-1:0]        position_q;
	logic                               is_locked_q;
	logic                               moved_out_q;

	ssp_pkg::ctl_t                      ctl;
	logic                               accept;
	logic                               out_busy;
	logic [ssp_pkg::QUO_W-1:0]          quo;
	logic [ssp_pkg::OPA_W-1:0]          num;
	logic [ssp_pkg::ANGLE_W-1:0]        deg_c;
	logic [ssp_pkg::PULSE_W-1:0]        pulse;
	logic [ssp_pkg::TIME_W-1:0]         diff;
	logic                               step;

	assign accept   = req_valid && ctl.idle;
	assign out_busy = rsp_valid_q && rsp_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= ssp_pkg::ENABLE_RST;
			lock_q     <= ssp_pkg::LOCK_RST;
			unlock_q   <= ssp_pkg::UNLOCK_RST;
			interval_q <= ssp_pkg::INTERVAL_RST;
		end else if (write_enable) begin
			unique case (ssp_pkg::cfg_reg_t'(write_index))
				ssp_pkg::REG_ENABLE:   enable_q   <= write_data[0];
				ssp_pkg::REG_LOCK:     lock_q     <= write_data[ssp_pkg::ANGLE_W-1:0];
				ssp_pkg::REG_UNLOCK:   unlock_q   <= write_data[ssp_pkg::ANGLE_W-1:0];
				ssp_pkg::REG_INTERVAL: interval_q <= write_data[ssp_pkg::INTERVAL_W-1:0];
			endcase
		end
	end

	// due when the signed difference is not negative
	assign diff = now_ms - next_q;
	assign step = enable_q && (cur_q != tgt_q) && (move_now_q || !diff[ssp_pkg::TIME_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= ssp_pkg::UNLOCK_RST;
			tgt_q      <= ssp_pkg::UNLOCK_RST;
			next_q     <= '0;
			move_now_q <= 1'b1;
			moved_q    <= 1'b0;
		end else if (accept) begin
			moved_q <= 1'b0;
			unique case (ssp_pkg::action_t'(action))
				ssp_pkg::ACT_LOCK: begin
					tgt_q      <= lock_q;
					move_now_q <= 1'b1;
				end
				ssp_pkg::ACT_UNLOCK: begin
					tgt_q      <= unlock_q;
					move_now_q <= 1'b1;
				end
				ssp_pkg::ACT_TICK: begin
					if (step) begin
						cur_q      <= (cur_q < tgt_q) ? cur_q + 1'b1 : cur_q - 1'b1;
						next_q     <= now_ms + ssp_pkg::TIME_W'(interval_q);
						move_now_q <= 1'b0;
						moved_q    <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// divider operand: clamped angle, then pulse width
	assign deg_c = (cur_q > ssp_pkg::ANGLE_W'(ssp_pkg::ANGLE_MAX))
	             ? ssp_pkg::ANGLE_W'(ssp_pkg::ANGLE_MAX) : cur_q;
	assign pulse = ssp_pkg::PULSE_W'(ssp_pkg::PULSE_BASE)
	             + ssp_pkg::PULSE_W'(quo[ssp_pkg::PULSE_Q_W-1:0]);

	always_comb begin
		unique case (ctl.div.sel)
			ssp_pkg::SEL_PULSE: num = ssp_pkg::OPA_W'(deg_c);
			ssp_pkg::SEL_DUTY:  num = pulse;
		endcase
	end

	ssp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_busy  (out_busy),
		.ctl       (ctl)
	);

	ssp_div u_div (
		.clk    (clk),
		.cmd    (ctl.div),
		.num    (num),
		.quo    (quo)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			duty_q      <= ssp_pkg::DUTY_W'(quo);
			position_q  <= cur_q;
			is_locked_q <= (cur_q == lock_q);
			moved_out_q <= moved_q;
		end
	end

	assign req_stall = !ctl.idle;
	assign rsp_valid = rsp_valid_q;
	assign duty      = duty_q;
	assign position  = position_q;
	assign is_locked = is_locked_q;
	assign moved     = moved_out_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted without going busy");

	a_duty_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (position >= ssp_pkg::ANGLE_W'(ssp_pkg::ANGLE_MAX)))
		|-> (duty == ssp_pkg::DUTY_AT_MAX))
		else $error("duty not clamped at full travel");

	a_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (position == '0)) |-> (duty == ssp_pkg::DUTY_AT_MIN))
		else $error("duty wrong at zero angle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !(rsp_valid_q && rsp_stall))
		else $error("response register overwritten while stalled");
`endif

endmodule
`default_nettype wire
